### rtl/ospfs_pkg.sv
`timescale 1ns / 1ps

package ospfs_pkg;

	localparam int unsigned VALUE_W  = 16;
	localparam int unsigned PRIME_W  = 9;
	localparam int unsigned SQUARE_W = 18;
	localparam int unsigned MULT_W   = 17;

	localparam logic [PRIME_W-1:0] FIRST_PRIME = 9'd3;
	localparam logic [VALUE_W-1:0] EVEN_FACTOR = 16'd2;

	localparam logic FUNC_BUILD = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_RST_CLEAR,
		ST_IDLE,
		ST_BLD_CLEAR,
		ST_PRIME_MUL,
		ST_PRIME_CHK,
		ST_PRIME_TEST,
		ST_MULT_CHK,
		ST_MULT_WR,
		ST_BLD_RESP,
		ST_QRY_READ,
		ST_QRY_RESP
	} state_t;

	typedef enum logic [1:0] {
		RD_QUERY,
		RD_PRIME,
		RD_MULT
	} rd_src_t;

	typedef struct packed {
		logic    take_item;
		logic    clr_init;
		logic    clr_wr;
		logic    p_init;
		logic    p_next;
		logic    pp_load;
		logic    m_load;
		logic    m_next;
		logic    rd_en;
		rd_src_t rd_src;
		logic    mult_wr;
		logic    out_load;
		logic    out_query;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic pp_over;
		logic m_over;
		logic entry_zero;
		logic out_free;
	} sts_t;

endpackage

### rtl/ospfs_req_if.sv
`timescale 1ns / 1ps

interface ospfs_req_if;
	logic                           valid;
	logic                           ready;
	logic                           func;
	logic [ospfs_pkg::VALUE_W-1:0]  query_value;

	modport source (output valid, output func, output query_value, input ready);
	modport sink (input valid, input func, input query_value, output ready);
endinterface

### rtl/ospfs_rsp_if.sv
`timescale 1ns / 1ps

interface ospfs_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [ospfs_pkg::VALUE_W-1:0]  factor;
	logic                           out_of_range;

	modport source (output valid, output factor, output out_of_range, input ready);
	modport sink (input valid, input factor, input out_of_range, output ready);
endinterface

### rtl/ospfs_cfg_if.sv
`timescale 1ns / 1ps

interface ospfs_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [ospfs_pkg::VALUE_W-1:0]  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/ospfs_ctrl.sv
`timescale 1ns / 1ps

module ospfs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_func,
	output logic                req_ready,
	input  ospfs_pkg::sts_t     sts,
	output ospfs_pkg::cmd_t     cmd
);

	ospfs_pkg::state_t state_q;
	ospfs_pkg::state_t state_d;
	logic              accept;

	assign req_ready = (state_q == ospfs_pkg::ST_IDLE);
	assign accept    = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ospfs_pkg::ST_RST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ospfs_pkg::ST_RST_CLEAR: begin
				if (sts.clr_last) state_d = ospfs_pkg::ST_IDLE;
			end
			ospfs_pkg::ST_IDLE: begin
				if (accept) begin
					if (req_func == ospfs_pkg::FUNC_BUILD) state_d = ospfs_pkg::ST_BLD_CLEAR;
					else state_d = ospfs_pkg::ST_QRY_READ;
				end
			end
			ospfs_pkg::ST_BLD_CLEAR: begin
				if (sts.clr_last) state_d = ospfs_pkg::ST_PRIME_MUL;
			end
			ospfs_pkg::ST_PRIME_MUL: begin
				state_d = ospfs_pkg::ST_PRIME_CHK;
			end
			ospfs_pkg::ST_PRIME_CHK: begin
				if (sts.pp_over) state_d = ospfs_pkg::ST_BLD_RESP;
				else state_d = ospfs_pkg::ST_PRIME_TEST;
			end
			ospfs_pkg::ST_PRIME_TEST: begin
				if (sts.entry_zero) state_d = ospfs_pkg::ST_MULT_CHK;
				else state_d = ospfs_pkg::ST_PRIME_MUL;
			end
			ospfs_pkg::ST_MULT_CHK: begin
				if (sts.m_over) state_d = ospfs_pkg::ST_PRIME_MUL;
				else state_d = ospfs_pkg::ST_MULT_WR;
			end
			ospfs_pkg::ST_MULT_WR: begin
				state_d = ospfs_pkg::ST_MULT_CHK;
			end
			ospfs_pkg::ST_BLD_RESP: begin
				if (sts.out_free) state_d = ospfs_pkg::ST_IDLE;
			end
			ospfs_pkg::ST_QRY_READ: begin
				state_d = ospfs_pkg::ST_QRY_RESP;
			end
			ospfs_pkg::ST_QRY_RESP: begin
				if (sts.out_free) state_d = ospfs_pkg::ST_IDLE;
			end
			default: begin
				state_d = ospfs_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.rd_src = ospfs_pkg::RD_QUERY;
		case (state_q)
			ospfs_pkg::ST_RST_CLEAR: begin
				cmd.clr_wr = 1'b1;
			end
			ospfs_pkg::ST_IDLE: begin
				cmd.take_item = accept;
				cmd.clr_init  = accept;
			end
			ospfs_pkg::ST_BLD_CLEAR: begin
				cmd.clr_wr = 1'b1;
				cmd.p_init = sts.clr_last;
			end
			ospfs_pkg::ST_PRIME_MUL: begin
				cmd.pp_load = 1'b1;
			end
			ospfs_pkg::ST_PRIME_CHK: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_src = ospfs_pkg::RD_PRIME;
			end
			ospfs_pkg::ST_PRIME_TEST: begin
				cmd.m_load = sts.entry_zero;
				cmd.p_next = !sts.entry_zero;
			end
			ospfs_pkg::ST_MULT_CHK: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_src = ospfs_pkg::RD_MULT;
				cmd.p_next = sts.m_over;
			end
			ospfs_pkg::ST_MULT_WR: begin
				cmd.mult_wr = 1'b1;
				cmd.m_next  = 1'b1;
			end
			ospfs_pkg::ST_BLD_RESP: begin
				cmd.out_load = sts.out_free;
			end
			ospfs_pkg::ST_QRY_READ: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_src = ospfs_pkg::RD_QUERY;
			end
			ospfs_pkg::ST_QRY_RESP: begin
				cmd.out_load  = sts.out_free;
				cmd.out_query = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

### rtl/ospfs_dpath.sv
`timescale 1ns / 1ps

module ospfs_dpath #(
	parameter int unsigned ODD_ENTRIES = 32768,
	parameter int unsigned FACTOR_BITS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ospfs_pkg::cmd_t                 cmd,
	output ospfs_pkg::sts_t                 sts,
	input  logic [ospfs_pkg::VALUE_W-1:0]   query_value,
	input  logic                            cfg_wr,
	input  logic [ospfs_pkg::VALUE_W-1:0]   cfg_data,
	input  logic                            rsp_ready,
	output logic                            rsp_valid,
	output logic [ospfs_pkg::VALUE_W-1:0]   rsp_factor,
	output logic                            rsp_out_of_range
);

	localparam int unsigned IDX_W = (ODD_ENTRIES > 1) ? $clog2(ODD_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(ODD_ENTRIES - 1);

	logic [ospfs_pkg::VALUE_W-1:0]  bound_q;
	logic [ospfs_pkg::VALUE_W-1:0]  value_q;
	logic [IDX_W-1:0]               clr_q;
	logic [ospfs_pkg::PRIME_W-1:0]  p_q;
	logic [ospfs_pkg::SQUARE_W-1:0] pp_q;
	logic [ospfs_pkg::MULT_W-1:0]   m_q;

	logic [FACTOR_BITS-1:0]         mem [ODD_ENTRIES];
	logic [FACTOR_BITS-1:0]         rdata_q;
	logic                           rd_ok_q;

	logic [31:0]                    rd_idx;
	logic [31:0]                    m_idx;
	logic                           m_ok;
	logic [FACTOR_BITS-1:0]         entry;
	logic                           we;
	logic [IDX_W-1:0]               waddr;
	logic [FACTOR_BITS-1:0]         wdata;

	logic                           out_valid_q;
	logic [ospfs_pkg::VALUE_W-1:0]  factor_q;
	logic                           oor_q;
	logic                           qry_oor;
	logic [ospfs_pkg::VALUE_W-1:0]  qry_factor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_q <= 16'hFFFF;
		end else if (cfg_wr) begin
			bound_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_item) value_q <= query_value;
	end

	// clear sweep counter, also starts the pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_init) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= clr_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.p_init) begin
			p_q <= ospfs_pkg::FIRST_PRIME;
		end else if (cmd.p_next) begin
			p_q <= p_q + ospfs_pkg::PRIME_W'(2);
		end
		if (cmd.pp_load) pp_q <= ospfs_pkg::SQUARE_W'(p_q) * ospfs_pkg::SQUARE_W'(p_q);
		if (cmd.m_load) begin
			m_q <= pp_q[ospfs_pkg::MULT_W-1:0];
		end else if (cmd.m_next) begin
			m_q <= m_q + ospfs_pkg::MULT_W'({p_q, 1'b0});
		end
	end

	assign m_idx = 32'(m_q >> 1);
	assign m_ok  = m_idx < ODD_ENTRIES;

	always_comb begin
		case (cmd.rd_src)
			ospfs_pkg::RD_PRIME: rd_idx = 32'(p_q >> 1);
			ospfs_pkg::RD_MULT:  rd_idx = m_idx;
			default:             rd_idx = 32'(value_q >> 1);
		endcase
	end

	assign entry = rd_ok_q ? rdata_q : '0;

	// multiples only take p where no smaller prime got there first
	assign we    = cmd.clr_wr || (cmd.mult_wr && m_ok && (entry == '0));
	assign waddr = cmd.clr_wr ? clr_q : m_idx[IDX_W-1:0];
	assign wdata = cmd.clr_wr ? '0 : FACTOR_BITS'(p_q);

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_idx[IDX_W-1:0]];
			rd_ok_q <= rd_idx < ODD_ENTRIES;
		end
	end

	assign qry_oor = value_q > bound_q;

	always_comb begin
		if (qry_oor) begin
			qry_factor = '0;
		end else if (!value_q[0]) begin
			qry_factor = ospfs_pkg::EVEN_FACTOR;
		end else if (entry == '0) begin
			qry_factor = value_q;
		end else begin
			qry_factor = ospfs_pkg::VALUE_W'(entry);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			factor_q <= cmd.out_query ? qry_factor : '0;
			oor_q    <= cmd.out_query && qry_oor;
		end
	end

	assign rsp_valid        = out_valid_q;
	assign rsp_factor       = factor_q;
	assign rsp_out_of_range = oor_q;

	assign sts.clr_last   = (clr_q == CLR_LAST);
	assign sts.pp_over    = pp_q > ospfs_pkg::SQUARE_W'(bound_q);
	assign sts.m_over     = m_q > ospfs_pkg::MULT_W'(bound_q);
	assign sts.entry_zero = (entry == '0);
	assign sts.out_free   = !out_valid_q || rsp_ready;

endmodule

### rtl/odd_smallest_prime_factor_sieve.sv
`timescale 1ns / 1ps

// smallest prime factor lookup for odd values, table built by a sieve
// req channel: func (build or query) and query_value; rsp channel: factor and
// out_of_range, exactly one rsp transaction per req transaction, in order
// cfg channel: writes upper_bound, always ready; write only while idle
// reset: all ODD_ENTRIES entries of the factor table are swept to zero; req.ready
// stays low during the sweep; upper_bound resets to 65535
// query: the table is read, then the result goes into the output register,
// which drives rsp valid; a new req is taken only after that result is loaded
// build: the table is cleared, then for each odd p from 3 with p*p <= bound
// the entry of p is read; for each p found prime (entry zero) its odd
// multiples from p*p up to the bound are read and, where still zero, written
// with p; once p*p passes the bound, the response is loaded
// stall: the output register holds a result while rsp.ready is low; one more
// req transaction is taken and worked, then the block waits for the slot
module odd_smallest_prime_factor_sieve #(
	parameter int unsigned ODD_ENTRIES = 32768,
	parameter int unsigned FACTOR_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	ospfs_req_if.sink   req,
	ospfs_rsp_if.source rsp,
	ospfs_cfg_if.sink   cfg
);

	ospfs_pkg::cmd_t cmd;
	ospfs_pkg::sts_t sts;
	logic            cfg_wr;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;

	ospfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_func  (req.func),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ospfs_dpath #(
		.ODD_ENTRIES (ODD_ENTRIES),
		.FACTOR_BITS (FACTOR_BITS)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.query_value      (req.query_value),
		.cfg_wr           (cfg_wr),
		.cfg_data         (cfg.data),
		.rsp_ready        (rsp.ready),
		.rsp_valid        (rsp.valid),
		.rsp_factor       (rsp.factor),
		.rsp_out_of_range (rsp.out_of_range)
	);

endmodule
